[hdl/cdfir_pkg.sv]
`timescale 1ns / 1ps

package cdfir_pkg;

    localparam int TAPS       = 41;
    localparam int DECIM      = 4;
    localparam int ACC_WIDTH  = 36;
    localparam int FRAC_SHIFT = 15;
    localparam int SAMPLE_W   = 16;
    localparam int PROD_W     = 2 * SAMPLE_W;
    localparam int PHASE_W    = (DECIM > 1) ? $clog2(DECIM) : 1;

    localparam logic KIND_DATA  = 1'b0;
    localparam logic KIND_COEFF = 1'b1;

    // Broadcast from the control logic to every cell
    typedef struct packed {
        logic                       load;
        logic                       clr;
        logic signed [SAMPLE_W-1:0] x_i;
        logic signed [SAMPLE_W-1:0] x_q;
        logic signed [SAMPLE_W-1:0] tap_wdata;
    } cdfir_ctrl_t;

endpackage

[hdl/cdfir_cell.sv]
`timescale 1ns / 1ps

module cdfir_cell
    import cdfir_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  cdfir_ctrl_t                 ctrl,
    input  logic                        tap_we,
    input  logic signed [ACC_WIDTH-1:0] partial_i_in,
    input  logic signed [ACC_WIDTH-1:0] partial_q_in,
    output logic signed [ACC_WIDTH-1:0] sum_i,
    output logic signed [ACC_WIDTH-1:0] sum_q,
    output logic signed [ACC_WIDTH-1:0] partial_i_out,
    output logic signed [ACC_WIDTH-1:0] partial_q_out
);

    logic signed [SAMPLE_W-1:0]  tap_reg;
    logic signed [ACC_WIDTH-1:0] partial_i_reg;
    logic signed [ACC_WIDTH-1:0] partial_q_reg;
    logic signed [PROD_W-1:0]    prod_i;
    logic signed [PROD_W-1:0]    prod_q;
    logic signed [ACC_WIDTH-1:0] up_i;
    logic signed [ACC_WIDTH-1:0] up_q;

    always_comb
    begin
        prod_i = ctrl.x_i * tap_reg;
        prod_q = ctrl.x_q * tap_reg;
        up_i   = ctrl.clr ? '0 : partial_i_in;
        up_q   = ctrl.clr ? '0 : partial_q_in;
        sum_i  = ACC_WIDTH'(prod_i) + up_i;
        sum_q  = ACC_WIDTH'(prod_q) + up_q;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_reg       <= '0;
            partial_i_reg <= '0;
            partial_q_reg <= '0;
        end
        else
        begin
            if (tap_we)
            begin
                tap_reg <= ctrl.tap_wdata;
            end
            if (ctrl.load)
            begin
                partial_i_reg <= sum_i;
                partial_q_reg <= sum_q;
            end
        end
    end

    assign partial_i_out = partial_i_reg;
    assign partial_q_out = partial_q_reg;

endmodule

[hdl/cdfir_out_buf.sv]
`timescale 1ns / 1ps

module cdfir_out_buf
    import cdfir_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic signed [SAMPLE_W-1:0] push_i,
    input  logic signed [SAMPLE_W-1:0] push_q,
    input  logic                       push_last,
    output logic                       full,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [SAMPLE_W-1:0] out_i,
    output logic signed [SAMPLE_W-1:0] out_q,
    output logic                       out_last
);

    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic signed [SAMPLE_W-1:0] out_i_reg;
    logic signed [SAMPLE_W-1:0] out_q_reg;
    logic                       out_last_reg;
    logic                       skid_valid_reg;
    logic                       skid_valid_next;
    logic signed [SAMPLE_W-1:0] skid_i_reg;
    logic signed [SAMPLE_W-1:0] skid_q_reg;
    logic                       skid_last_reg;
    logic                       out_free;
    logic                       out_load;
    logic                       skid_load;

    always_comb
    begin
        out_free        = !out_valid_reg || !out_stall;
        out_load        = 1'b0;
        skid_load       = 1'b0;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_load        = 1'b1;
                out_valid_next  = 1'b1;
                skid_load       = push;
                skid_valid_next = push;
            end
            else
            begin
                out_load       = push;
                out_valid_next = push;
            end
        end
        else if (push)
        begin
            skid_load       = 1'b1;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_i_reg    <= skid_valid_reg ? skid_i_reg : push_i;
            out_q_reg    <= skid_valid_reg ? skid_q_reg : push_q;
            out_last_reg <= skid_valid_reg ? skid_last_reg : push_last;
        end
        if (skid_load)
        begin
            skid_i_reg    <= push_i;
            skid_q_reg    <= push_q;
            skid_last_reg <= push_last;
        end
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_i     = out_i_reg;
    assign out_q     = out_q_reg;
    assign out_last  = out_last_reg;

endmodule

[hdl/complex_decimating_fir_unit.sv]
`timescale 1ns / 1ps

// Complex decimating FIR: one 41-tap transposed-form filter shared by the I and Q
// rails, decimating by 4. One item (data sample or coefficient write) is taken
// every cycle while in_stall is low; each of the 41 cells holds one tap and one
// pair of 36-bit wrapping partial sums and has its own two 16x16 multipliers, so
// all taps update in the cycle the sample is taken. Every fourth data sample
// after a start yields one result on out_valid; start_req clears the partial
// sums and the decimation phase before its sample. Outputs are bits [30:15] of
// the filter sum. A two-entry output buffer lets input continue while a result
// waits; in_stall rises only when both entries are occupied.
module complex_decimating_fir_unit
    import cdfir_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       kind,
    input  logic signed [SAMPLE_W-1:0] sample_i,
    input  logic signed [SAMPLE_W-1:0] sample_q,
    input  logic                       frame_end,
    input  logic                       start_req,
    input  logic [5:0]                 coeff_index,
    input  logic signed [SAMPLE_W-1:0] coeff_value,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [SAMPLE_W-1:0] out_i,
    output logic signed [SAMPLE_W-1:0] out_q,
    output logic                       out_last
);

    cdfir_ctrl_t                 ctrl;
    logic                        in_xfer;
    logic                        data_xfer;
    logic                        coeff_xfer;
    logic                        produce;
    logic                        full;
    logic [PHASE_W-1:0]          phase_reg;
    logic [PHASE_W-1:0]          phase_next;
    logic [PHASE_W-1:0]          phase_eff;
    logic [TAPS-1:0]             tap_we;
    logic signed [ACC_WIDTH-1:0] sum_i     [TAPS];
    logic signed [ACC_WIDTH-1:0] sum_q     [TAPS];
    logic signed [ACC_WIDTH-1:0] partial_i [TAPS+1];
    logic signed [ACC_WIDTH-1:0] partial_q [TAPS+1];

    assign in_stall   = full;
    assign in_xfer    = in_valid && !full;
    assign data_xfer  = in_xfer && (kind == KIND_DATA);
    assign coeff_xfer = in_xfer && (kind == KIND_COEFF);

    always_comb
    begin
        ctrl.load      = data_xfer;
        ctrl.clr       = start_req;
        ctrl.x_i       = sample_i;
        ctrl.x_q       = sample_q;
        ctrl.tap_wdata = coeff_value;

        phase_eff  = start_req ? '0 : phase_reg;
        produce    = data_xfer && (32'(phase_eff) >= DECIM - 1);
        phase_next = phase_reg;
        if (data_xfer)
        begin
            phase_next = produce ? '0 : PHASE_W'(phase_eff + 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    assign partial_i[TAPS] = '0;
    assign partial_q[TAPS] = '0;

    for (genvar k = 0; k < TAPS; k++)
    begin : g_cell
        assign tap_we[k] = coeff_xfer && (32'(coeff_index) == k);

        cdfir_cell u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .ctrl          (ctrl),
            .tap_we        (tap_we[k]),
            .partial_i_in  (partial_i[k+1]),
            .partial_q_in  (partial_q[k+1]),
            .sum_i         (sum_i[k]),
            .sum_q         (sum_q[k]),
            .partial_i_out (partial_i[k]),
            .partial_q_out (partial_q[k])
        );
    end

    cdfir_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (produce),
        .push_i    (sum_i[0][FRAC_SHIFT+SAMPLE_W-1:FRAC_SHIFT]),
        .push_q    (sum_q[0][FRAC_SHIFT+SAMPLE_W-1:FRAC_SHIFT]),
        .push_last (frame_end),
        .full      (full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_i     (out_i),
        .out_q     (out_q),
        .out_last  (out_last)
    );

endmodule
